[sv/mpw_pkg.sv]
// Shared types, constants and modular helpers for the matrix power block.
// No dependencies; all other files use these by scoped names.
package mpw_pkg;

    localparam int unsigned VAL_W   = 30;
    localparam int unsigned EXP_W   = 60;
    localparam int unsigned SIZE_W  = 7;
    localparam int unsigned CSIZE_W = 6;
    localparam int unsigned CIDX_W  = 1;

    localparam logic [VAL_W-1:0] PRIME    = 30'd1000000007;
    localparam logic [31:0]      PRIME_X2 = 32'd2000000014;
    // floor(2^61 / PRIME) for the Barrett quotient estimate
    localparam logic [31:0]      BARRETT_M = 32'd2305842993;

    localparam logic [CIDX_W-1:0] CFG_SIZE = 1'b0;
    localparam logic [CIDX_W-1:0] CFG_EXP  = 1'b1;

    typedef struct packed {
        logic [VAL_W-1:0]  value;
        logic              last;
        logic [SIZE_W-1:0] size;
        logic [EXP_W-1:0]  exp;
    } mpw_item_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_IDENT,
        ST_CHECK,
        ST_MUL,
        ST_MWAIT,
        ST_COPY,
        ST_CWAIT,
        ST_SUM,
        ST_SWAIT,
        ST_OUT
    } mpw_state_t;

    function automatic logic [VAL_W-1:0] mod_add(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
        logic [VAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, PRIME})
            s = s - {1'b0, PRIME};
        return s[VAL_W-1:0];
    endfunction

endpackage

[sv/mpw_front.sv]
// Front end: configuration registers, entry reduction, load counting and
// a two-word queue toward the compute back end. Uses mpw_pkg.
module mpw_front #(
    parameter int unsigned MAX_SIZE = 32,
    localparam int unsigned AW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE * MAX_SIZE) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mpw_pkg::CIDX_W-1:0]    cfg_index,
    input  logic [mpw_pkg::EXP_W-1:0]     cfg_data,
    input  logic                          entry_valid,
    output logic                          entry_stall,
    input  logic [mpw_pkg::VAL_W-1:0]     entry_value,
    output logic                          q_valid,
    input  logic                          q_pop,
    output mpw_pkg::mpw_item_t            q_item,
    output logic [AW-1:0]                 q_addr
);

    localparam int unsigned CW = $clog2(MAX_SIZE * MAX_SIZE + 1);
    localparam int unsigned PW = 2 * mpw_pkg::SIZE_W;

    logic [mpw_pkg::CSIZE_W-1:0] size_reg;
    logic [mpw_pkg::EXP_W-1:0]   exp_reg;
    logic [CW-1:0]               load_count_reg;
    logic [CW-1:0]               load_count_next;

    mpw_pkg::mpw_item_t          q_item_reg [2];
    logic [AW-1:0]               q_addr_reg [2];
    logic                        wr_ptr_reg;
    logic                        rd_ptr_reg;
    logic [1:0]                  count_reg;

    logic [mpw_pkg::SIZE_W-1:0]  n;
    logic [PW-1:0]               n_sq;
    logic [CW-1:0]               cells;
    logic [CW-1:0]               lc;
    logic                        last;
    logic                        push;
    logic [mpw_pkg::VAL_W-1:0]   v_red;
    mpw_pkg::mpw_item_t          push_item;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        n = {1'b0, size_reg};
        if (n == '0)
            n = mpw_pkg::SIZE_W'(1);
        if (n > mpw_pkg::SIZE_W'(MAX_SIZE))
            n = mpw_pkg::SIZE_W'(MAX_SIZE);
    end

    assign n_sq  = PW'(n) * PW'(n);
    assign cells = CW'(n_sq);

    // a size change mid-load can leave the count past the end
    assign lc   = (load_count_reg >= cells) ? (cells - CW'(1)) : load_count_reg;
    assign last = ((lc + CW'(1)) == cells);
    assign load_count_next = last ? '0 : (lc + CW'(1));

    assign v_red = (entry_value >= mpw_pkg::PRIME) ? (entry_value - mpw_pkg::PRIME)
                                                   : entry_value;

    assign entry_stall = (count_reg == 2'd2);
    assign push        = entry_valid && !entry_stall;

    always_comb
    begin
        push_item.value = v_red;
        push_item.last  = last;
        push_item.size  = n;
        push_item.exp   = exp_reg;
    end

    assign q_valid = (count_reg != 2'd0);
    assign q_item  = q_item_reg[rd_ptr_reg];
    assign q_addr  = q_addr_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg       <= mpw_pkg::CSIZE_W'(1);
            exp_reg        <= '0;
            load_count_reg <= '0;
            wr_ptr_reg     <= 1'b0;
            rd_ptr_reg     <= 1'b0;
            count_reg      <= 2'd0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    mpw_pkg::CFG_SIZE: size_reg <= cfg_data[mpw_pkg::CSIZE_W-1:0];
                    mpw_pkg::CFG_EXP:  exp_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (push)
            begin
                load_count_reg <= load_count_next;
                wr_ptr_reg     <= ~wr_ptr_reg;
            end
            if (q_pop && q_valid)
                rd_ptr_reg <= ~rd_ptr_reg;
            case ({push, q_pop && q_valid})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_item_reg[wr_ptr_reg] <= push_item;
            q_addr_reg[wr_ptr_reg] <= lc[AW-1:0];
        end
    end

endmodule

[sv/mpw_modmac.sv]
// Pipelined modular multiply-accumulate: 30x30 product, Barrett reduction,
// running sum per output entry. Uses mpw_pkg constants and mod_add.
module mpw_modmac #(
    parameter int unsigned MAX_SIZE = 32,
    localparam int unsigned AW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE * MAX_SIZE) : 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_first,
    input  logic                       in_last,
    input  logic [AW-1:0]              in_addr,
    input  logic [mpw_pkg::VAL_W-1:0]  a,
    input  logic [mpw_pkg::VAL_W-1:0]  b,
    output logic                       busy,
    output logic                       wr_valid,
    output logic [AW-1:0]              wr_addr,
    output logic [mpw_pkg::VAL_W-1:0]  wr_data
);

    logic          valid_reg [4];
    logic          first_reg [4];
    logic          last_reg  [4];
    logic [AW-1:0] addr_reg  [4];

    logic [59:0]   prod_reg;
    logic [62:0]   qm_reg;
    logic [31:0]   xl2_reg;
    logic [31:0]   qp_reg;
    logic [31:0]   xl3_reg;
    logic [mpw_pkg::VAL_W-1:0] rr_reg;
    logic [mpw_pkg::VAL_W-1:0] acc_reg;

    logic [60:0]   qp_full;
    logic [31:0]   r3;
    logic [31:0]   r3_red;
    logic [mpw_pkg::VAL_W-1:0] acc_next;

    // quotient estimate is at most two short, so r3 < 3*PRIME
    assign qp_full = qm_reg[62:32] * mpw_pkg::PRIME;
    assign r3      = xl3_reg - qp_reg;

    always_comb
    begin
        if (r3 >= mpw_pkg::PRIME_X2)
            r3_red = r3 - mpw_pkg::PRIME_X2;
        else if (r3 >= 32'(mpw_pkg::PRIME))
            r3_red = r3 - 32'(mpw_pkg::PRIME);
        else
            r3_red = r3;
    end

    assign acc_next = first_reg[3] ? rr_reg : mpw_pkg::mod_add(acc_reg, rr_reg);

    assign busy     = valid_reg[0] || valid_reg[1] || valid_reg[2] || valid_reg[3];
    assign wr_valid = valid_reg[3] && last_reg[3];
    assign wr_addr  = addr_reg[3];
    assign wr_data  = acc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                valid_reg[i] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < 4; i++)
                valid_reg[i] <= valid_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg[0] <= in_first;
        last_reg[0]  <= in_last;
        addr_reg[0]  <= in_addr;
        for (int i = 1; i < 4; i++)
        begin
            first_reg[i] <= first_reg[i-1];
            last_reg[i]  <= last_reg[i-1];
            addr_reg[i]  <= addr_reg[i-1];
        end
        prod_reg <= 60'(a) * 60'(b);
        qm_reg   <= 63'(prod_reg[59:29]) * 63'(mpw_pkg::BARRETT_M);
        xl2_reg  <= prod_reg[31:0];
        qp_reg   <= qp_full[31:0];
        xl3_reg  <= xl2_reg;
        rr_reg   <= r3_red[mpw_pkg::VAL_W-1:0];
        if (valid_reg[3])
            acc_reg <= acc_next;
    end

endmodule

[sv/mpw_back.sv]
// Back end: matrix stores, identity setup, square-and-multiply sequencer,
// copy-back sweeps and final entry sum. Uses mpw_pkg and mpw_modmac.
module mpw_back #(
    parameter int unsigned MAX_SIZE = 32,
    localparam int unsigned AW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE * MAX_SIZE) : 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    output logic                       q_pop,
    input  mpw_pkg::mpw_item_t         q_item,
    input  logic [AW-1:0]              q_addr,
    output logic                       sum_valid,
    input  logic                       sum_stall,
    output logic [mpw_pkg::VAL_W-1:0]  entry_sum
);

    localparam int unsigned CELLS = MAX_SIZE * MAX_SIZE;
    localparam int unsigned IW    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int unsigned PW    = 2 * mpw_pkg::SIZE_W;

    mpw_pkg::mpw_state_t state_reg;
    mpw_pkg::mpw_state_t state_next;

    logic [mpw_pkg::VAL_W-1:0] base_mem    [CELLS];
    logic [mpw_pkg::VAL_W-1:0] power_mem   [CELLS];
    logic [mpw_pkg::VAL_W-1:0] scratch_mem [CELLS];

    logic [mpw_pkg::SIZE_W-1:0] n_reg;
    logic [AW-1:0]              cells_m1_reg;
    logic [mpw_pkg::EXP_W-1:0]  exp_reg;
    logic                       sq_reg;      // 1: squaring base, 0: power times base
    logic [AW-1:0]              idx_reg;
    logic [IW-1:0]              r_reg;
    logic [IW-1:0]              c_reg;
    logic [IW-1:0]              t_reg;
    logic [AW-1:0]              row_reg;
    logic [AW-1:0]              ay_reg;

    logic                       iss_valid_reg;
    logic                       iss_first_reg;
    logic                       iss_last_reg;
    logic [AW-1:0]              iss_addr_reg;
    logic [mpw_pkg::VAL_W-1:0]  base_rda_reg;
    logic [mpw_pkg::VAL_W-1:0]  base_rdb_reg;
    logic [mpw_pkg::VAL_W-1:0]  power_rd_reg;
    logic [mpw_pkg::VAL_W-1:0]  scratch_rd_reg;
    logic                       cp_valid_reg;
    logic [AW-1:0]              cp_addr_reg;
    logic                       sm_valid_reg;
    logic [mpw_pkg::VAL_W-1:0]  acc_reg;
    logic                       sum_valid_reg;
    logic [mpw_pkg::VAL_W-1:0]  sum_reg;

    logic [IW-1:0]              nm1;
    logic [AW-1:0]              n_aw;
    logic [AW-1:0]              ax;
    logic [AW-1:0]              az;
    logic                       idx_last;
    logic                       t_last;
    logic                       c_last;
    logic                       r_last;
    logic [PW-1:0]              item_sq;

    logic                       base_we;
    logic [AW-1:0]              base_wa;
    logic [mpw_pkg::VAL_W-1:0]  base_wd;
    logic                       power_we;
    logic [AW-1:0]              power_wa;
    logic [mpw_pkg::VAL_W-1:0]  power_wd;
    logic [AW-1:0]              power_ra;
    logic                       issue;

    logic                       mac_busy;
    logic                       mac_wr_valid;
    logic [AW-1:0]              mac_wr_addr;
    logic [mpw_pkg::VAL_W-1:0]  mac_wr_data;

    assign nm1      = IW'(n_reg - mpw_pkg::SIZE_W'(1));
    assign n_aw     = AW'(n_reg);
    assign ax       = row_reg + AW'(t_reg);
    assign az       = row_reg + AW'(c_reg);
    assign idx_last = (idx_reg == cells_m1_reg);
    assign t_last   = (t_reg == nm1);
    assign c_last   = (c_reg == nm1);
    assign r_last   = (r_reg == nm1);
    assign item_sq  = PW'(q_item.size) * PW'(q_item.size);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mpw_pkg::ST_LOAD:
                if (q_valid && q_item.last)
                    state_next = mpw_pkg::ST_IDENT;
            mpw_pkg::ST_IDENT:
                if (idx_last)
                    state_next = mpw_pkg::ST_CHECK;
            mpw_pkg::ST_CHECK:
                state_next = (exp_reg == '0) ? mpw_pkg::ST_SUM : mpw_pkg::ST_MUL;
            mpw_pkg::ST_MUL:
                if (t_last && c_last && r_last)
                    state_next = mpw_pkg::ST_MWAIT;
            mpw_pkg::ST_MWAIT:
                if (!iss_valid_reg && !mac_busy)
                    state_next = mpw_pkg::ST_COPY;
            mpw_pkg::ST_COPY:
                if (idx_last)
                    state_next = mpw_pkg::ST_CWAIT;
            mpw_pkg::ST_CWAIT:
                state_next = sq_reg ? mpw_pkg::ST_CHECK : mpw_pkg::ST_MUL;
            mpw_pkg::ST_SUM:
                if (idx_last)
                    state_next = mpw_pkg::ST_SWAIT;
            mpw_pkg::ST_SWAIT:
                state_next = mpw_pkg::ST_OUT;
            mpw_pkg::ST_OUT:
                if (sum_valid_reg && !sum_stall)
                    state_next = mpw_pkg::ST_LOAD;
            default:
                state_next = mpw_pkg::ST_LOAD;
        endcase
    end

    // datapath controls
    always_comb
    begin
        q_pop    = (state_reg == mpw_pkg::ST_LOAD) && q_valid;
        issue    = (state_reg == mpw_pkg::ST_MUL);
        base_we  = q_pop || (cp_valid_reg && sq_reg);
        base_wa  = q_pop ? q_addr : cp_addr_reg;
        base_wd  = q_pop ? q_item.value : scratch_rd_reg;
        power_we = (state_reg == mpw_pkg::ST_IDENT) || (cp_valid_reg && !sq_reg);
        if (state_reg == mpw_pkg::ST_IDENT)
        begin
            power_wa = idx_reg;
            power_wd = (r_reg == c_reg) ? mpw_pkg::VAL_W'(1) : '0;
        end
        else
        begin
            power_wa = cp_addr_reg;
            power_wd = scratch_rd_reg;
        end
        power_ra = (state_reg == mpw_pkg::ST_SUM) ? idx_reg : ax;
    end

    always_ff @(posedge clk)
    begin
        if (base_we)
            base_mem[base_wa] <= base_wd;
        base_rda_reg <= base_mem[ax];
        base_rdb_reg <= base_mem[ay_reg];
    end

    always_ff @(posedge clk)
    begin
        if (power_we)
            power_mem[power_wa] <= power_wd;
        power_rd_reg <= power_mem[power_ra];
    end

    always_ff @(posedge clk)
    begin
        if (mac_wr_valid)
            scratch_mem[mac_wr_addr] <= mac_wr_data;
        scratch_rd_reg <= scratch_mem[idx_reg];
    end

    mpw_modmac #(
        .MAX_SIZE (MAX_SIZE)
    ) u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (iss_valid_reg),
        .in_first (iss_first_reg),
        .in_last  (iss_last_reg),
        .in_addr  (iss_addr_reg),
        .a        (sq_reg ? base_rda_reg : power_rd_reg),
        .b        (base_rdb_reg),
        .busy     (mac_busy),
        .wr_valid (mac_wr_valid),
        .wr_addr  (mac_wr_addr),
        .wr_data  (mac_wr_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mpw_pkg::ST_LOAD;
            iss_valid_reg <= 1'b0;
            cp_valid_reg  <= 1'b0;
            sm_valid_reg  <= 1'b0;
            sum_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iss_valid_reg <= issue;
            cp_valid_reg  <= (state_reg == mpw_pkg::ST_COPY);
            sm_valid_reg  <= (state_reg == mpw_pkg::ST_SUM);
            if (sum_valid_reg && !sum_stall)
                sum_valid_reg <= 1'b0;
            else if ((state_reg == mpw_pkg::ST_OUT) && !sum_valid_reg)
                sum_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        iss_first_reg <= (t_reg == '0);
        iss_last_reg  <= t_last;
        iss_addr_reg  <= az;
        cp_addr_reg   <= idx_reg;
        if (sm_valid_reg)
            acc_reg <= mpw_pkg::mod_add(acc_reg, power_rd_reg);
        if ((state_reg == mpw_pkg::ST_OUT) && !sum_valid_reg)
            sum_reg <= acc_reg;

        case (state_reg)
            mpw_pkg::ST_LOAD:
            begin
                if (q_pop && q_item.last)
                begin
                    n_reg        <= q_item.size;
                    exp_reg      <= q_item.exp;
                    cells_m1_reg <= AW'(item_sq - PW'(1));
                    idx_reg      <= '0;
                    r_reg        <= '0;
                    c_reg        <= '0;
                end
            end
            mpw_pkg::ST_IDENT:
            begin
                idx_reg <= idx_reg + AW'(1);
                if (c_last)
                begin
                    c_reg <= '0;
                    r_reg <= r_reg + IW'(1);
                end
                else
                    c_reg <= c_reg + IW'(1);
            end
            mpw_pkg::ST_CHECK:
            begin
                sq_reg  <= !exp_reg[0];
                idx_reg <= '0;
                acc_reg <= '0;
                r_reg   <= '0;
                c_reg   <= '0;
                t_reg   <= '0;
                row_reg <= '0;
                ay_reg  <= '0;
            end
            mpw_pkg::ST_MUL:
            begin
                if (t_last)
                begin
                    t_reg <= '0;
                    if (c_last)
                    begin
                        c_reg   <= '0;
                        ay_reg  <= '0;
                        r_reg   <= r_reg + IW'(1);
                        row_reg <= row_reg + n_aw;
                    end
                    else
                    begin
                        c_reg  <= c_reg + IW'(1);
                        ay_reg <= AW'(c_reg) + AW'(1);
                    end
                end
                else
                begin
                    t_reg  <= t_reg + IW'(1);
                    ay_reg <= ay_reg + n_aw;
                end
            end
            mpw_pkg::ST_MWAIT:
                idx_reg <= '0;
            mpw_pkg::ST_COPY,
            mpw_pkg::ST_SUM:
                idx_reg <= idx_reg + AW'(1);
            mpw_pkg::ST_CWAIT:
            begin
                if (sq_reg)
                    exp_reg <= exp_reg >> 1;
                else
                    sq_reg <= 1'b1;
                r_reg   <= '0;
                c_reg   <= '0;
                t_reg   <= '0;
                row_reg <= '0;
                ay_reg  <= '0;
            end
            default: ;
        endcase
    end

    assign sum_valid = sum_valid_reg;
    assign entry_sum = sum_reg;

endmodule

[sv/matrix_power_walk_count.sv]
// After the last of n*n entries, the identity is first set up in the power store,
// then per exponent bit one squaring plus, for a set bit, one extra product; each
// product is a sweep of n^3 terms through the MAC pipeline, which takes one term a
// cycle, and a copy-back sweep; then the power's entries are summed. Entries are
// taken one per cycle while loading unless the queue is full. Reset clears control,
// load count, matrix_size to 1 and exponent to 0; stores are not cleared.
module matrix_power_walk_count #(
    parameter int unsigned MAX_SIZE = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [mpw_pkg::CIDX_W-1:0]  cfg_index,
    input  logic [mpw_pkg::EXP_W-1:0]   cfg_data,
    input  logic                        entry_valid,
    output logic                        entry_stall,
    input  logic [mpw_pkg::VAL_W-1:0]   entry_value,
    output logic                        sum_valid,
    input  logic                        sum_stall,
    output logic [mpw_pkg::VAL_W-1:0]   entry_sum
);

    localparam int unsigned AW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE * MAX_SIZE) : 1;

    logic               q_valid;
    logic               q_pop;
    mpw_pkg::mpw_item_t q_item;
    logic [AW-1:0]      q_addr;

    mpw_front #(
        .MAX_SIZE (MAX_SIZE)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .entry_valid (entry_valid),
        .entry_stall (entry_stall),
        .entry_value (entry_value),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_item      (q_item),
        .q_addr      (q_addr)
    );

    mpw_back #(
        .MAX_SIZE (MAX_SIZE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .q_addr    (q_addr),
        .sum_valid (sum_valid),
        .sum_stall (sum_stall),
        .entry_sum (entry_sum)
    );

endmodule
